### rtl/core/hash_set_intersection_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hash set intersection core
// Clocked property checks on clk, with and without the rst disable.
// ----------------------------------------------------------------------------
`ifndef HASH_SET_INTERSECTION_CORE_ASSERT_SVH
`define HASH_SET_INTERSECTION_CORE_ASSERT_SVH

// Check a property on every clk edge outside reset.
`define HSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property on every clk edge, reset included.
`define HSI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### rtl/core/hsi_pkg.sv
// ----------------------------------------------------------------------------
// hsi_pkg
// Shared constants, codes and interface structs of the set intersection core.
// ----------------------------------------------------------------------------
package hsi_pkg;

  // Table depth must be a power of two: the home slot is the value's low bits.
  localparam int TABLE_DEPTH = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_PROBE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_DONE
  } state_t;

  // Sequencer to table: one read and one write port, plus a run clear.
  typedef struct packed {
    logic                   rd;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr;
    logic [IDX_W-1:0]       wr_addr;
    logic [VALUE_WIDTH-1:0] wr_key;
    logic                   clr;
  } tbl_req_t;

  // Registered read data, valid in the cycle after rd.
  typedef struct packed {
    logic                   valid;
    logic [VALUE_WIDTH-1:0] key;
  } tbl_rsp_t;

  typedef struct packed {
    logic                   found;
    logic [VALUE_WIDTH-1:0] value;
    logic                   overflow;
  } result_t;

endpackage

### rtl/core/hash_set_intersection_core.sv
// ----------------------------------------------------------------------------
// hash_set_intersection_core
// Hash-join intersection of two integer lists with duplicate suppression.
// ----------------------------------------------------------------------------
// Stream one list as insert words (command 0) and the other as probe words
// (command 1); every word returns exactly one result word. A probe that hits
// a stored value different from the last reported one comes back with found
// set and the value on common_value. An insert into a full table is dropped
// and flagged by overflow. A word with last set clears the table after its
// result is formed. The table has 256 slots with linear probing; an accepted
// item walks the slots of its probe path (one key memory read and compare
// per cycle), then waits in a done state until its result is taken; only
// then is the next word accepted. A finished result waits in an output
// register, so the next word is taken while it is held.
// ----------------------------------------------------------------------------
module hash_set_intersection_core import hsi_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic signed [VALUE_WIDTH-1:0] common_value,
  output logic                          overflow
);

`include "hash_set_intersection_core_assert.svh"

  tbl_req_t         req;
  tbl_rsp_t         rsp;
  result_t          res;
  logic             res_valid;
  logic             res_take;
  logic [CNT_W-1:0] count;

  hsi_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .value    ($unsigned(value)),
    .last     (last),
    .req      (req),
    .rsp      (rsp),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take),
    .count    (count)
  );

  hsi_table u_table (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Load the output word when it is empty or being drained this cycle.
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      found        <= res.found;
      common_value <= signed'(res.value);
      overflow     <= res.overflow;
    end
  end

  `HSI_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "accepted while busy")
  `HSI_ASSERT(a_count_bound, count <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
  `HSI_ASSERT(a_flags_exclusive, out_valid |-> !(found && overflow), "found with overflow")
  `HSI_ASSERT(a_zero_on_miss, out_valid && !found |-> common_value == '0, "value without hit")
  `HSI_ASSERT_RST(a_reset_idle, !rst && $past(rst) |-> !out_valid && in_ready, "not idle after reset")

endmodule

### rtl/core/hsi_table.sv
// ----------------------------------------------------------------------------
// hsi_table
// Slot key memory with registered read, and per-slot valid flops.
// ----------------------------------------------------------------------------
module hsi_table import hsi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  tbl_req_t req,
  output tbl_rsp_t rsp
);

  logic [VALUE_WIDTH-1:0] keys [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_bits;
  logic [VALUE_WIDTH-1:0] rd_key;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      keys[req.wr_addr] <= req.wr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd_key   <= keys[req.rd_addr];
      rd_valid <= valid_bits[req.rd_addr];
    end
  end

  // Clear wins over a same-cycle insert: a last item empties the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (req.clr) begin
      valid_bits <= '0;
    end else if (req.wr) begin
      valid_bits[req.wr_addr] <= 1'b1;
    end
  end

  assign rsp.key   = rd_key;
  assign rsp.valid = rd_valid;

endmodule

### rtl/core/hsi_seq.sv
// ----------------------------------------------------------------------------
// hsi_seq
// Probe sequencer: walks the linear probe path one slot a cycle through a
// single key compare, then applies the insert or the emit decision.
// ----------------------------------------------------------------------------
module hsi_seq import hsi_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   command,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   last,
  output tbl_req_t               req,
  input  tbl_rsp_t               rsp,
  output logic                   res_valid,
  output result_t                res,
  input  logic                   res_take,
  output logic [CNT_W-1:0]       count
);

  state_t                 state, state_next;
  cmd_t                   cmd_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic                   last_q;
  logic [IDX_W-1:0]       pos;
  logic [IDX_W-1:0]       n;
  logic                   hit_q;
  logic                   free_q;
  logic [VALUE_WIDTH-1:0] prev;
  logic                   have;

  logic                   key_eq;
  logic                   path_end;
  logic                   ins_ok;
  logic                   do_insert;
  logic                   do_found;

  assign key_eq   = (rsp.key == val_q);
  assign path_end = (n == IDX_W'(TABLE_DEPTH - 1));
  assign ins_ok   = free_q && (count < CNT_W'(TABLE_DEPTH));
  assign do_insert = (cmd_q == CMD_INSERT) && !hit_q && ins_ok;
  assign do_found  = (cmd_q == CMD_PROBE) && hit_q && (!have || (prev != val_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    req         = '0;
    req.rd_addr = pos + 1'b1;
    req.wr_addr = pos;
    req.wr_key  = val_q;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req.rd      = 1'b1;
          req.rd_addr = value[IDX_W-1:0];
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        // Empty slot, key match or full wrap ends the walk; else advance.
        if (rsp.valid && !key_eq && !path_end) begin
          req.rd = 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          req.wr     = do_insert;
          req.clr    = last_q;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_q  <= cmd_t'(command);
      val_q  <= value;
      last_q <= last;
      pos    <= value[IDX_W-1:0];
      n      <= '0;
    end else if (state == S_CMP) begin
      if (!rsp.valid) begin
        hit_q  <= 1'b0;
        free_q <= 1'b1;
      end else if (key_eq) begin
        hit_q  <= 1'b1;
        free_q <= 1'b0;
      end else if (path_end) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        pos <= pos + 1'b1;
        n   <= n + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      prev  <= '0;
      have  <= 1'b0;
    end else if (state == S_DONE && res_take) begin
      if (last_q) begin
        count <= '0;
        prev  <= '0;
        have  <= 1'b0;
      end else begin
        if (do_insert) begin
          count <= count + 1'b1;
        end
        if (do_found) begin
          prev <= val_q;
          have <= 1'b1;
        end
      end
    end
  end

  assign res.found    = do_found;
  assign res.value    = do_found ? val_q : '0;
  assign res.overflow = (cmd_q == CMD_INSERT) && !hit_q && !ins_ok;

endmodule
